/* hw/rtl/avi_riff_stream_demux_unit_macros.svh */
// Assertion helpers used by the demux RTL file.
`ifndef AVI_RIFF_STREAM_DEMUX_UNIT_MACROS_SVH
`define AVI_RIFF_STREAM_DEMUX_UNIT_MACROS_SVH
// Check that cond implies prop on every clock edge outside reset.
`define ARSD_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Check that cond implies prop on the next clock edge.
`define ARSD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

/* hw/rtl/arsd_pkg.sv */
`default_nettype none
package arsd_pkg;
    localparam int OFFSET_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        PH_SIG, PH_HDR, PH_LTYPE, PH_DATA, PH_MHDR, PH_PAY, PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        K_HEADER = 3'd0, K_VIDEO = 3'd1, K_AUDIO = 3'd2, K_DONE = 3'd3, K_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_DISPLAY_WIDTH = 3'd0, REG_FEED_HEIGHT = 3'd1, REG_FRAME_BUFFER = 3'd2,
        REG_AUDIO_ENABLE = 3'd3, REG_DEFAULT_RATE = 3'd4
    } reg_index_t;

    localparam logic [31:0] TAG_RIFF  = 32'h52494646;
    localparam logic [31:0] TAG_AVI   = 32'h41564920;
    localparam logic [31:0] TAG_LIST  = 32'h4C495354;
    localparam logic [31:0] TAG_MOVI  = 32'h6D6F7669;
    localparam logic [31:0] TAG_HDRL  = 32'h6864726C;
    localparam logic [31:0] TAG_STRL  = 32'h7374726C;
    localparam logic [31:0] TAG_AVIH  = 32'h61766968;
    localparam logic [31:0] TAG_STRH  = 32'h73747268;
    localparam logic [31:0] TAG_STRF  = 32'h73747266;
    localparam logic [31:0] TAG_00DC  = 32'h30306463;
    localparam logic [31:0] TAG_01WB  = 32'h30317762;
    localparam logic [31:0] TAG_IDX1  = 32'h69647831;
    localparam logic [31:0] WORD_VIDS = 32'h73646976;
    localparam logic [31:0] DEF_FRAME_PERIOD = 32'd66666;
    localparam logic [31:0] BIG_WIDTH  = 32'd800;
    localparam logic [31:0] BIG_HEIGHT = 32'd600;
    localparam logic [31:0] MIN_BIH    = 32'd40;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic        chunk_end;
        logic [31:0] frame_period;
        logic [31:0] total_frames;
        logic [15:0] video_width;
        logic [15:0] video_height;
        logic [31:0] audio_rate;
        logic [15:0] channels;
        logic [1:0]  scale_code;
        logic [15:0] out_width;
        logic [15:0] out_height;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_t;
endpackage
`default_nettype wire

/* hw/rtl/arsd_if.sv */
`default_nettype none
interface arsd_item_if;
    import arsd_pkg::*;
    logic  valid;
    logic  ready;
    item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface arsd_result_if;
    import arsd_pkg::*;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface arsd_cfg_if;
    import arsd_pkg::*;
    logic valid;
    logic ready;
    cfg_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/avi_riff_stream_demux_unit.sv */
// AVI byte-stream demultiplexer. Feed the file one byte per transaction on
// in_ch; mark byte 0 with first_byte and the last byte with end_of_file. The
// block checks the RIFF/AVI signature, walks hdrl/strl, and at LIST movi emits
// one header result (timing, sizes, audio format, JPEG downscale), then one
// result per forwarded video (00dc) or audio (01wb) byte, and a done or error
// result at the end. Most bytes give no result. Throughput is one byte per
// clock: each byte updates the parser registers straight from the input
// register, and a two-entry output buffer keeps input flowing while a result
// waits on out_ch; input stalls only while both entries hold results.
// Configuration writes on cfg_ch are taken at any time but belong between
// files.
`default_nettype none
`include "avi_riff_stream_demux_unit_macros.svh"
module avi_riff_stream_demux_unit
    import arsd_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    arsd_item_if.sink     in_ch,
    arsd_result_if.source out_ch,
    arsd_cfg_if.sink      cfg_ch
);
    localparam int OW = OFFSET_WIDTH;

    // configuration
    logic [12:0] disp_w_reg, feed_h_reg;
    logic [23:0] fb_bytes_reg;
    logic        audio_en_reg;
    logic [31:0] def_rate_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_w_reg   <= 13'd240;
            feed_h_reg   <= 13'd240;
            fb_bytes_reg <= 24'd115200;
            audio_en_reg <= 1'b1;
            def_rate_reg <= 32'd16000;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.payload.index)
                REG_DISPLAY_WIDTH: disp_w_reg   <= cfg_ch.payload.data[12:0];
                REG_FEED_HEIGHT:   feed_h_reg   <= cfg_ch.payload.data[12:0];
                REG_FRAME_BUFFER:  fb_bytes_reg <= cfg_ch.payload.data[23:0];
                REG_AUDIO_ENABLE:  audio_en_reg <= cfg_ch.payload.data[0];
                REG_DEFAULT_RATE:  def_rate_reg <= cfg_ch.payload.data;
                default: ;
            endcase
        end
    end

    // input register
    logic  in_v_reg;
    item_t in_reg;
    logic  accept_in;
    logic  step;

    // output buffer, two entries
    logic    [1:0] cnt_reg;
    result_t buf_reg [2];
    logic    res_v;
    result_t res;

    // input stage advances only when the buffer has room for any result
    assign step        = in_v_reg && (cnt_reg != 2'd2);
    assign in_ch.ready = !in_v_reg || step;
    assign accept_in   = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_ch.ready)
            in_v_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
            in_reg <= in_ch.payload;
    end

    // parser state
    logic [OW-1:0] off_reg, off_next;
    phase_t        ph_reg, ph_next;
    logic [3:0]    fc_reg, fc_next;
    logic [31:0]   tag_reg, tag_next;
    logic [31:0]   size_reg, size_next;
    logic [OW-1:0] cnext_reg, cnext_next;
    logic [OW-1:0] mend_reg, mend_next;
    logic          vid_reg, vid_next;
    logic [31:0]   hf_reg [6];
    logic [31:0]   hf_next [6];

    // scale selection from stored size
    logic [1:0]  sc;
    logic [15:0] ow16, oh16;
    logic [31:0] wv, hv;
    logic [33:0] ow_full, oh_full;

    always_comb
    begin
        wv = hf_reg[2];
        hv = hf_reg[3];
        if (wv >= BIG_WIDTH || hv >= BIG_HEIGHT)
            sc = 2'd3;
        else if (wv >= 32'(disp_w_reg) * 32'd3 && hv >= 32'(feed_h_reg) * 32'd3)
            sc = 2'd2;
        else if (wv >= 32'(disp_w_reg) * 32'd2 && hv >= 32'(feed_h_reg) * 32'd2)
            sc = 2'd1;
        else
            sc = 2'd0;
        ow_full = ({2'b0, wv} + ((34'd1 << sc) - 34'd1)) >> sc;
        oh_full = ({2'b0, hv} + ((34'd1 << sc) - 34'd1)) >> sc;
        ow16 = ow_full[15:0];
        oh16 = oh_full[15:0];
    end

    // frame bytes check registered: sizes only change before movi
    logic [31:0] prod_reg;
    logic        fits_reg;
    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(ow16) * 32'(oh16);
        fits_reg <= ({prod_reg, 1'b0} <= 33'(fb_bytes_reg));
    end

    always_comb
    begin
        logic [7:0]    b;
        logic [OW-1:0] off, off1, ds, st, nx, dstart, idx;
        logic [2:0]    fc;
        logic [31:0]   sz, w, t;
        logic          hdr_done, last, pad;
        logic [1:0]    mode;
        logic [2:0]    bodykind;
        logic          eof;

        b = in_reg.data_byte;
        eof = in_reg.end_of_file;
        ph_next = ph_reg; fc_next = fc_reg; tag_next = tag_reg; size_next = size_reg;
        cnext_next = cnext_reg; mend_next = mend_reg; vid_next = vid_reg;
        off = off_reg;
        for (int i = 0; i < 6; i++)
            hf_next[i] = hf_reg[i];
        if (in_reg.first_byte)
        begin
            off = '0; ph_next = PH_SIG; fc_next = '0; tag_next = '0; size_next = '0;
            cnext_next = '0; mend_next = '0; vid_next = 1'b0;
            hf_next[0] = DEF_FRAME_PERIOD; hf_next[1] = '0; hf_next[2] = '0;
            hf_next[3] = '0; hf_next[4] = def_rate_reg; hf_next[5] = 32'd1;
        end
        off1 = off + OW'(1);
        res_v = 1'b0;
        res = '0;
        hdr_done = 1'b0;
        ds = off1; st = off - OW'(7); nx = '0; sz = '0; w = '0; t = '0;
        dstart = '0; idx = '0; last = 1'b0; pad = 1'b0; mode = '0; bodykind = '0;
        fc = fc_next[2:0];

        // chunk header collection shared by hdr and movi-header phases
        if (ph_next == PH_HDR || (ph_next == PH_MHDR &&
            !(fc == 3'd0 && off >= mend_next)))
        begin
            sz = (fc == 3'd0) ? 32'd0 : size_next;
            if (fc < 3'd4)
                tag_next = {tag_next[23:0], b};
            else
                sz = sz | (32'(b) << (5'd8 * 5'(fc - 3'd4)));
            size_next = sz;
            fc_next = {1'b0, fc} + 4'd1;
            if (fc == 3'd7)
            begin
                fc_next = '0;
                nx = ds + OW'(sz) + OW'(sz[0]);
                if (nx <= st)
                begin
                    res_v = 1'b1; res.kind = K_ERROR;
                end
                else
                begin
                    cnext_next = nx;
                    hdr_done = 1'b1;
                end
            end
        end

        unique case (ph_next)
            PH_SIG:
            begin
                tag_next = {tag_next[23:0], b};
                if ((off == OW'(3) && tag_next != TAG_RIFF) || off > OW'(11))
                begin
                    res_v = 1'b1; res.kind = K_ERROR;
                end
                else if (off == OW'(11))
                begin
                    if (tag_next != TAG_AVI)
                    begin
                        res_v = 1'b1; res.kind = K_ERROR;
                    end
                    else
                    begin
                        ph_next = PH_HDR; fc_next = '0;
                    end
                end
            end
            PH_HDR:
            begin
                if (hdr_done)
                begin
                    t = tag_next;
                    if (t == TAG_LIST)
                    begin
                        if (size_next < 32'd4)
                        begin
                            res_v = 1'b1; res.kind = K_ERROR;
                        end
                        else
                        begin
                            ph_next = PH_LTYPE; fc_next = '0;
                        end
                    end
                    else
                    begin
                        if (t == TAG_AVIH && size_next >= 32'd20) bodykind = 3'd1;
                        else if (t == TAG_STRH && size_next >= 32'd8) bodykind = 3'd2;
                        else if (t == TAG_STRF && size_next >= 32'd16) bodykind = 3'd3;
                        fc_next = '0;
                        if (off1 != cnext_next)
                        begin
                            ph_next = PH_DATA; fc_next = {1'b0, bodykind};
                        end
                    end
                end
            end
            PH_LTYPE:
            begin
                tag_next = {tag_next[23:0], b};
                fc_next = fc_next + 4'd1;
                if (fc_next >= 4'd4)
                begin
                    fc_next = '0;
                    if (tag_next == TAG_MOVI)
                    begin
                        mend_next = cnext_next - OW'(size_next[0]);
                        ph_next = PH_MHDR;
                        res_v = 1'b1;
                        if (hf_next[2] == 32'd0)
                            res.kind = K_ERROR;
                        else
                        begin
                            res.kind = K_HEADER;
                            res.frame_period = hf_next[0];
                            res.total_frames = hf_next[1];
                            res.video_width  = hf_next[2][15:0];
                            res.video_height = hf_next[3][15:0];
                            res.audio_rate   = (hf_next[4] != 32'd0) ? hf_next[4]
                                                                     : def_rate_reg;
                            res.channels     = hf_next[5][15:0];
                            res.scale_code   = sc;
                            res.out_width    = ow16;
                            res.out_height   = oh16;
                        end
                    end
                    else if (tag_next == TAG_HDRL || tag_next == TAG_STRL)
                        ph_next = PH_HDR;
                    else if (off1 != cnext_next)
                        ph_next = PH_DATA;
                    else
                        ph_next = PH_HDR;
                end
            end
            PH_DATA:
            begin
                dstart = cnext_next - OW'(size_next) - OW'(size_next[0]);
                idx = off - dstart;
                tag_next = {b, tag_next[31:8]};
                w = tag_next;
                if (idx[1:0] == 2'd3 && idx < OW'(20))
                begin
                    case (fc_next[1:0])
                        2'd1:
                        begin
                            if (idx == OW'(3)) hf_next[0] = w;
                            if (idx == OW'(19)) hf_next[1] = w;
                        end
                        2'd2:
                            if (idx == OW'(3)) vid_next = (w == WORD_VIDS);
                        2'd3:
                        begin
                            if (vid_next)
                            begin
                                if (idx == OW'(3) && w >= MIN_BIH) fc_next[2] = 1'b1;
                                if (idx == OW'(7) && fc_next[2]) hf_next[2] = {16'd0, w[15:0]};
                                if (idx == OW'(11) && fc_next[2])
                                    hf_next[3] = {16'd0, w[31] ? 16'(32'd0 - w) : w[15:0]};
                            end
                            else
                            begin
                                if (idx == OW'(3)) hf_next[5] = {16'd0, w[31:16]};
                                if (idx == OW'(7)) hf_next[4] = w;
                            end
                        end
                        default: ;
                    endcase
                end
                if (off1 == cnext_next)
                begin
                    ph_next = PH_HDR; fc_next = '0;
                end
            end
            PH_MHDR:
            begin
                if (fc == 3'd0 && off >= mend_next)
                begin
                    res_v = 1'b1; res.kind = K_DONE;
                end
                else if (hdr_done)
                begin
                    t = tag_next;
                    if (t == TAG_IDX1)
                    begin
                        res_v = 1'b1; res.kind = K_DONE;
                    end
                    else
                    begin
                        if (t == TAG_00DC && size_next != 32'd0)
                            mode = fits_reg ? 2'd1 : 2'd0;
                        else if (t == TAG_01WB && size_next != 32'd0 && audio_en_reg)
                            mode = 2'd2;
                        fc_next = '0;
                        if (off1 != cnext_next)
                        begin
                            ph_next = PH_PAY; fc_next = {2'b0, mode};
                        end
                    end
                end
            end
            PH_PAY:
            begin
                last = (off1 == cnext_next);
                pad = last && size_next[0];
                if (fc_next[1:0] != 2'd0 && !pad)
                begin
                    res_v = 1'b1;
                    res.kind = (fc_next[1:0] == 2'd1) ? K_VIDEO : K_AUDIO;
                    res.payload_byte = b;
                    res.chunk_end = (off1 == cnext_next - OW'(size_next[0]));
                end
                if (last)
                begin
                    ph_next = PH_MHDR; fc_next = '0;
                end
            end
            PH_IDLE: ;
            default: ph_next = PH_IDLE;
        endcase
        if (res_v && (res.kind == K_DONE || res.kind == K_ERROR))
            ph_next = PH_IDLE;
        off_next = off1;
        if (eof && ph_next != PH_IDLE)
        begin
            if (!res_v)
            begin
                res_v = 1'b1;
                res.kind = (ph_next == PH_MHDR || ph_next == PH_PAY) ? K_DONE : K_ERROR;
            end
            ph_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0; ph_reg <= PH_SIG; fc_reg <= '0; tag_reg <= '0;
            size_reg <= '0; cnext_reg <= '0; mend_reg <= '0; vid_reg <= 1'b0;
            hf_reg[0] <= DEF_FRAME_PERIOD; hf_reg[1] <= '0; hf_reg[2] <= '0;
            hf_reg[3] <= '0; hf_reg[4] <= 32'd16000; hf_reg[5] <= 32'd1;
        end
        else if (step)
        begin
            off_reg <= off_next; ph_reg <= ph_next; fc_reg <= fc_next;
            tag_reg <= tag_next; size_reg <= size_next; cnext_reg <= cnext_next;
            mend_reg <= mend_next; vid_reg <= vid_next;
            for (int i = 0; i < 6; i++)
                hf_reg[i] <= hf_next[i];
        end
    end

    // output buffer: entry 0 is the head
    logic push, pop;
    assign push = step && res_v;
    assign pop  = out_ch.valid && out_ch.ready;
    assign out_ch.valid   = (cnt_reg != 2'd0);
    assign out_ch.payload = buf_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
            if (push)
                buf_reg[cnt_reg == 2'd2 ? 1 : 0] <= res;
        end
        else if (push)
            buf_reg[cnt_reg[0]] <= res;
    end

    `ARSD_ASSERT_IMPL(a_no_overflow, clk, rst_n, push && !pop, cnt_reg != 2'd2,
        "result buffer overflow")
    `ARSD_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, cnt_reg != 2'd0,
        "result buffer underflow")
    `ARSD_ASSERT_IMPL(a_idle_sticks, clk, rst_n,
        step && ph_reg == PH_IDLE && !in_reg.first_byte, !res_v,
        "idle phase produced results")
endmodule
`default_nettype wire

/* tb/sv/arsd_demux_checker.sv */
module arsd_demux_checker
    import arsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    arsd_item_if   in_ch,
    arsd_result_if out_ch,
    arsd_cfg_if    cfg_ch,
    output int     errors,
    output int     pending
);
    // register copies
    logic [31:0] disp_w, feed_h, fbuf_bytes, dflt_rate;
    logic        aud_en;

    // parser copy
    phase_t      ph;
    logic [31:0] offs, tag, csize, cnext, mend;
    logic [3:0]  fcnt;
    logic        vid;
    logic [31:0] hf [6];

    result_t     res;
    bit          has;
    result_t     expected_q [$];

    task automatic start_file();
        offs  = '0;
        ph    = PH_SIG;
        fcnt  = '0;
        tag   = '0;
        csize = '0;
        cnext = '0;
        mend  = '0;
        vid   = 1'b0;
        hf[0] = DEF_FRAME_PERIOD;
        hf[1] = '0;
        hf[2] = '0;
        hf[3] = '0;
        hf[4] = dflt_rate;
        hf[5] = 32'd1;
    endtask

    task automatic emit(kind_t k);
        res      = '0;
        res.kind = k;
        has      = 1'b1;
        if (k == K_DONE || k == K_ERROR)
            ph = PH_IDLE;
    endtask

    function automatic logic [1:0] pick_scale(input logic [31:0] w, input logic [31:0] h,
                                              output logic [31:0] ow, output logic [31:0] oh);
        logic [1:0] sc;
        sc = 2'd0;
        if (w >= BIG_WIDTH || h >= BIG_HEIGHT)
            sc = 2'd3;
        else if (w >= disp_w * 3 && h >= feed_h * 3)
            sc = 2'd2;
        else if (w >= disp_w * 2 && h >= feed_h * 2)
            sc = 2'd1;
        ow = (w + (32'd1 << sc) - 32'd1) >> sc;
        oh = (h + (32'd1 << sc) - 32'd1) >> sc;
        return sc;
    endfunction

    // collect one chunk header byte; ok once all eight are in and the size is sane
    task automatic collect(input logic [7:0] b, input logic [31:0] off, output bit ok);
        logic [2:0]  fc;
        logic [31:0] st, nx;
        fc = fcnt[2:0];
        ok = 1'b0;
        if (fc == 0)
            csize = '0;
        if (fc < 4)
            tag = {tag[23:0], b};
        else
            csize = csize | (32'(b) << (8 * (fc - 4)));
        fcnt = {1'b0, fc} + 4'd1;
        if (fc == 3'd7) begin
            fcnt = '0;
            st = off - 32'd7;
            nx = off + 32'd1 + csize + csize[0];
            if (nx <= st)
                emit(K_ERROR);
            else begin
                cnext = nx;
                ok = 1'b1;
            end
        end
    endtask

    task automatic enter_body(input logic [31:0] off, input phase_t body,
                              input logic [3:0] mode, input phase_t hdr);
        fcnt = '0;
        if (off + 32'd1 == cnext)
            ph = hdr;
        else begin
            ph = body;
            fcnt = mode;
        end
    endtask

    task automatic take_field(input logic [7:0] b, input logic [31:0] off);
        logic [31:0] idx, w;
        idx = off - (cnext - csize - csize[0]);
        tag = {b, tag[31:8]};
        if (idx[1:0] == 2'd3 && idx < 20) begin
            w = tag;
            case (fcnt[1:0])
                2'd1: begin
                    if (idx == 3) hf[0] = w;
                    if (idx == 19) hf[1] = w;
                end
                2'd2: if (idx == 3) vid = (w == WORD_VIDS);
                2'd3: begin
                    if (vid) begin
                        if (idx == 3 && w >= MIN_BIH) fcnt[2] = 1'b1;
                        if (idx == 7 && fcnt[2]) hf[2] = {16'd0, w[15:0]};
                        if (idx == 11 && fcnt[2]) hf[3] = (w[31] ? -w : w) & 32'hFFFF;
                    end else begin
                        if (idx == 3) hf[5] = w >> 16;
                        if (idx == 7) hf[4] = w;
                    end
                end
                default: ;
            endcase
        end
        if (off + 32'd1 == cnext) begin
            ph = PH_HDR;
            fcnt = '0;
        end
    endtask

    task automatic movi_header();
        logic [31:0] ow, oh;
        logic [1:0]  sc;
        if (hf[2] == 0)
            emit(K_ERROR);
        else begin
            sc = pick_scale(hf[2], hf[3], ow, oh);
            emit(K_HEADER);
            res.frame_period = hf[0];
            res.total_frames = hf[1];
            res.video_width  = hf[2][15:0];
            res.video_height = hf[3][15:0];
            res.audio_rate   = (hf[4] != 0) ? hf[4] : dflt_rate;
            res.channels     = hf[5][15:0];
            res.scale_code   = sc;
            res.out_width    = ow[15:0];
            res.out_height   = oh[15:0];
        end
    endtask

    task automatic demux_byte(input item_t it);
        logic [7:0]  b;
        logic [31:0] off, nxt, ow, oh;
        logic [63:0] need;
        logic [3:0]  mode;
        bit          ok, last, pad;
        b   = it.data_byte;
        has = 1'b0;
        res = '0;
        if (it.first_byte)
            start_file();
        off = offs;
        case (ph)
            PH_SIG: begin
                tag = {tag[23:0], b};
                if ((off == 3 && tag != TAG_RIFF) || off > 11)
                    emit(K_ERROR);
                else if (off == 11) begin
                    if (tag != TAG_AVI)
                        emit(K_ERROR);
                    else begin
                        ph = PH_HDR;
                        fcnt = '0;
                    end
                end
            end
            PH_HDR: begin
                collect(b, off, ok);
                if (ok) begin
                    if (tag == TAG_LIST) begin
                        if (csize < 4)
                            emit(K_ERROR);
                        else begin
                            ph = PH_LTYPE;
                            fcnt = '0;
                        end
                    end else begin
                        mode = (tag == TAG_AVIH && csize >= 20) ? 4'd1 :
                               (tag == TAG_STRH && csize >= 8)  ? 4'd2 :
                               (tag == TAG_STRF && csize >= 16) ? 4'd3 : 4'd0;
                        enter_body(off, PH_DATA, mode, PH_HDR);
                    end
                end
            end
            PH_LTYPE: begin
                tag  = {tag[23:0], b};
                fcnt = fcnt + 4'd1;
                if (fcnt >= 4) begin
                    fcnt = '0;
                    if (tag == TAG_MOVI) begin
                        mend = cnext - csize[0];
                        ph = PH_MHDR;
                        movi_header();
                    end else if (tag == TAG_HDRL || tag == TAG_STRL)
                        ph = PH_HDR;
                    else
                        enter_body(off, PH_DATA, 4'd0, PH_HDR);
                end
            end
            PH_DATA: take_field(b, off);
            PH_MHDR: begin
                if (fcnt[2:0] == 0 && off >= mend)
                    emit(K_DONE);
                else begin
                    collect(b, off, ok);
                    if (ok) begin
                        if (tag == TAG_IDX1)
                            emit(K_DONE);
                        else begin
                            mode = 4'd0;
                            if (tag == TAG_00DC && csize > 0) begin
                                void'(pick_scale(hf[2], hf[3], ow, oh));
                                need = 64'(ow) * 64'(oh) * 64'd2;
                                if (need <= 64'(fbuf_bytes))
                                    mode = 4'd1;
                            end else if (tag == TAG_01WB && csize > 0 && aud_en)
                                mode = 4'd2;
                            enter_body(off, PH_PAY, mode, PH_MHDR);
                        end
                    end
                end
            end
            PH_PAY: begin
                mode = {2'd0, fcnt[1:0]};
                nxt  = off + 32'd1;
                last = (nxt == cnext);
                pad  = last && csize[0];
                if (mode != 0 && !pad) begin
                    emit(mode == 1 ? K_VIDEO : K_AUDIO);
                    res.payload_byte = b;
                    res.chunk_end    = (nxt == cnext - csize[0]);
                end
                if (last) begin
                    ph = PH_MHDR;
                    fcnt = '0;
                end
            end
            default: ph = PH_IDLE;
        endcase
        offs = off + 32'd1;
        if (it.end_of_file && ph != PH_IDLE) begin
            if (!has)
                emit((ph == PH_MHDR || ph == PH_PAY) ? K_DONE : K_ERROR);
            ph = PH_IDLE;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want, got;
        if (!rst_n) begin
            disp_w     = 32'd240;
            feed_h     = 32'd240;
            fbuf_bytes = 32'd115200;
            aud_en     = 1'b1;
            dflt_rate  = 32'd16000;
            start_file();
            expected_q.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.payload.index)
                    REG_DISPLAY_WIDTH: disp_w     = {19'd0, cfg_ch.payload.data[12:0]};
                    REG_FEED_HEIGHT:   feed_h     = {19'd0, cfg_ch.payload.data[12:0]};
                    REG_FRAME_BUFFER:  fbuf_bytes = {8'd0, cfg_ch.payload.data[23:0]};
                    REG_AUDIO_ENABLE:  aud_en     = cfg_ch.payload.data[0];
                    REG_DEFAULT_RATE:  dflt_rate  = cfg_ch.payload.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                demux_byte(in_ch.payload);
                if (has)
                    expected_q.push_back(res);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("chunk_end", want.chunk_end, got.chunk_end);
                    check_field("frame_period", want.frame_period, got.frame_period);
                    check_field("total_frames", want.total_frames, got.total_frames);
                    check_field("video_width", want.video_width, got.video_width);
                    check_field("video_height", want.video_height, got.video_height);
                    check_field("audio_rate", want.audio_rate, got.audio_rate);
                    check_field("channels", want.channels, got.channels);
                    check_field("scale_code", want.scale_code, got.scale_code);
                    check_field("out_width", want.out_width, got.out_width);
                    check_field("out_height", want.out_height, got.out_height);
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

/* tb/sv/tb_avi_riff_stream_demux_unit.sv */
module tb_avi_riff_stream_demux_unit;
    import arsd_pkg::*;

    // index past the register file; the block must ignore it
    localparam logic [2:0] REG_NONE = 3'd5;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    arsd_item_if   in_ch ();
    arsd_result_if out_ch ();
    arsd_cfg_if    cfg_ch ();

    int errors;
    int pending;
    int tx_gap_pct   = 22;
    int rx_stall_pct = 88;
    int bytes_sent   = 0;

    avi_riff_stream_demux_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    arsd_demux_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    // Receiver: drop ready at random per the current stall rate.
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);

    // Hard stop in case the block hangs.
    initial begin
        #4000000;
        $display("FAIL avi_riff_stream_demux_unit");
        $finish;
    end

    // Push one byte transaction; hold valid high across back-to-back bytes so
    // that it is never lowered and raised in the same step.
    task automatic send_byte(input item_t it);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file(ref logic [7:0] fq[$], input bit mark_first, input bit mark_eof);
        item_t it;
        foreach (fq[i]) begin
            it.data_byte   = fq[i];
            it.first_byte  = mark_first && (i == 0);
            it.end_of_file = mark_eof && (i == fq.size() - 1);
            send_byte(it);
        end
    endtask

    // Drain all expected results, then let the pipeline settle before touching
    // configuration; bytes that cause no result may still be in flight.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_ch.payload <= '{index: idx, data: value};
        cfg_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Tags go out in text order, sizes and fields little-endian.
    task automatic put_tag(ref logic [7:0] fq[$], input logic [31:0] t);
        for (int k = 3; k >= 0; k--)
            fq.push_back(t[8*k +: 8]);
    endtask

    task automatic put_word(ref logic [7:0] fq[$], input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            fq.push_back(v[8*k +: 8]);
    endtask

    task automatic put_chunk(ref logic [7:0] fq[$], input logic [31:0] t, input int len);
        put_tag(fq, t);
        put_word(fq, len);
        repeat (len + (len & 1))
            fq.push_back($urandom_range(255));
    endtask

    // Build one AVI file: mostly well formed with random content, sometimes
    // with broken sizes, odd chunks, missing pieces or a flipped byte.
    task automatic build_file(ref logic [7:0] fq[$]);
        logic [7:0]  movi_q[$];
        logic [31:0] w, h, t;
        int          len, n;
        fq.delete();
        w = ($urandom_range(99) < 70) ? $urandom_range(8, 400) : $urandom_range(0, 1000);
        if ($urandom_range(99) < 5)
            w = 0;
        if ($urandom_range(99) < 3)
            w = $urandom;
        h = ($urandom_range(99) < 70) ? $urandom_range(8, 300) : $urandom_range(0, 800);
        if ($urandom_range(99) < 25)
            h = -h;
        put_tag(fq, TAG_RIFF);
        put_word(fq, $urandom);
        put_tag(fq, TAG_AVI);
        put_tag(fq, TAG_LIST);
        put_word(fq, ($urandom_range(99) < 3) ? $urandom_range(0, 3) : 32'd300);
        put_tag(fq, TAG_HDRL);
        // main header: period at 0, frame count at 16; sometimes too short
        put_tag(fq, TAG_AVIH);
        if ($urandom_range(99) < 5) begin
            put_word(fq, 16);
            repeat (16) fq.push_back($urandom_range(255));
        end else begin
            put_word(fq, 56);
            put_word(fq, $urandom);
            repeat (3) put_word(fq, $urandom);
            put_word(fq, $urandom);
            repeat (9) put_word(fq, $urandom);
        end
        if ($urandom_range(99) < 30) begin
            // unknown chunk, odd size, or a size that wraps the offset
            put_tag(fq, 32'h4A554E4B);
            if ($urandom_range(99) < 10) begin
                put_word(fq, 32'hFFFFFFFE);
            end else begin
                len = $urandom_range(1, 5);
                put_word(fq, len);
                repeat (len + (len & 1)) fq.push_back($urandom_range(255));
            end
        end
        // video stream list
        put_tag(fq, TAG_LIST);
        put_word(fq, 120);
        put_tag(fq, TAG_STRL);
        put_tag(fq, TAG_STRH);
        put_word(fq, 56);
        put_word(fq, ($urandom_range(99) < 92) ? WORD_VIDS : $urandom);
        repeat (52) fq.push_back($urandom_range(255));
        put_tag(fq, TAG_STRF);
        put_word(fq, 40);
        put_word(fq, ($urandom_range(99) < 90) ? MIN_BIH : $urandom_range(0, 39));
        put_word(fq, w);
        put_word(fq, h);
        repeat (28) fq.push_back($urandom_range(255));
        if ($urandom_range(99) < 70) begin
            // audio stream list: channels at bytes 2..3, rate at 4..7
            put_tag(fq, TAG_LIST);
            put_word(fq, 100);
            put_tag(fq, TAG_STRL);
            put_tag(fq, TAG_STRH);
            put_word(fq, 8);
            put_tag(fq, 32'h61756473);
            put_word(fq, $urandom);
            put_tag(fq, TAG_STRF);
            put_word(fq, 16);
            fq.push_back(8'd1);
            fq.push_back(8'd0);
            fq.push_back($urandom_range(0, 3));
            fq.push_back(($urandom_range(99) < 10) ? $urandom_range(255) : 8'd0);
            put_word(fq, ($urandom_range(99) < 15) ? 32'd0 : $urandom_range(8000, 48000));
            repeat (8) fq.push_back($urandom_range(255));
        end
        // payload list
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    t = TAG_00DC;
                    len = $urandom_range(0, 9);
                end
                3, 4: begin
                    t = TAG_01WB;
                    len = $urandom_range(0, 7);
                end
                default: begin
                    t = 32'h30317478;
                    len = $urandom_range(0, 3);
                end
            endcase
            put_chunk(movi_q, t, len);
        end
        put_tag(fq, TAG_LIST);
        put_word(fq, ($urandom_range(99) < 85) ? 4 + movi_q.size() : $urandom_range(4, 40));
        put_tag(fq, TAG_MOVI);
        foreach (movi_q[i])
            fq.push_back(movi_q[i]);
        if ($urandom_range(99) < 40)
            put_chunk(fq, TAG_IDX1, 16);
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 6)) fq.push_back($urandom_range(255));
        if ($urandom_range(99) < 8)
            fq[$urandom_range(0, fq.size() - 1)] = $urandom_range(255);
        if ($urandom_range(99) < 10)
            fq = fq[0 : $urandom_range(1, fq.size() - 1)];
    endtask

    initial begin
        logic [7:0] fq[$];
        int         phase_base;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset settings. Bad first tag with no start mark,
        // then two bytes the idle parser must ignore.
        fq = '{8'h52, 8'h49, 8'h46, 8'h58, 8'h00, 8'hFF};
        send_file(fq, 1'b0, 1'b0);
        // bad form type at byte 11
        fq.delete();
        put_tag(fq, TAG_RIFF);
        put_word(fq, 32'hFFFFFFFF);
        put_tag(fq, 32'h41564958);
        send_file(fq, 1'b1, 1'b0);
        // file ends before movi
        fq.delete();
        put_tag(fq, TAG_RIFF);
        fq.push_back(8'h00);
        send_file(fq, 1'b1, 1'b1);
        // one generated file with the default rates
        build_file(fq);
        send_file(fq, 1'b1, $urandom_range(99) < 85);
        drain();

        // Random part: three idle profiles, each with its own register set.
        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: begin
                    tx_gap_pct = 22;
                    rx_stall_pct = 88;
                    write_reg(REG_DISPLAY_WIDTH, 1);
                    write_reg(REG_FEED_HEIGHT, 1);
                    write_reg(REG_FRAME_BUFFER, 24'hFFFFFF);
                    write_reg(REG_AUDIO_ENABLE, 0);
                    write_reg(REG_DEFAULT_RATE, 0);
                end
                1: begin
                    tx_gap_pct = 88;
                    rx_stall_pct = 22;
                    write_reg(REG_DISPLAY_WIDTH, 4096);
                    write_reg(REG_FEED_HEIGHT, 4096);
                    write_reg(REG_FRAME_BUFFER, 0);
                    write_reg(REG_AUDIO_ENABLE, 1);
                    write_reg(REG_DEFAULT_RATE, 32'hFFFFFFFF);
                    write_reg(REG_NONE, $urandom);
                end
                default: begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                    write_reg(REG_DISPLAY_WIDTH, $urandom_range(1, 200));
                    write_reg(REG_FEED_HEIGHT, $urandom_range(1, 150));
                    write_reg(REG_FRAME_BUFFER, $urandom_range(0, 200000));
                    write_reg(REG_DEFAULT_RATE, $urandom);
                end
            endcase
            phase_base = bytes_sent;
            while (bytes_sent - phase_base < 350) begin
                build_file(fq);
                send_file(fq, 1'b1, $urandom_range(99) < 85);
            end
            drain();
        end

        if (errors == 0)
            $display("PASS avi_riff_stream_demux_unit");
        else
            $display("FAIL avi_riff_stream_demux_unit");
        $finish;
    end
endmodule
